// ===== hdl/ipd_pkg.sv =====
package ipd_pkg;

    localparam int unsigned IPD_QUEUE_DEPTH = 2;

    localparam logic [7:0] TICK_RESET = 8'd85;

    // Durations in ticks.
    localparam logic [6:0] HDR_MARK_T   = 7'd106;
    localparam logic [6:0] BIT_MARK_T   = 7'd8;
    localparam logic [8:0] HDR_SPACE_T  = 9'd53;
    localparam logic [8:0] ONE_SPACE_T  = 9'd18;
    localparam logic [8:0] ZERO_SPACE_T = 9'd6;
    localparam logic [8:0] GAP_SPACE_T  = 9'd235;
    localparam logic [8:0] GAP_MULT     = 9'd2;
    localparam logic [8:0] DGAP_SPACE_T = 9'(GAP_MULT * GAP_SPACE_T);

    // Byte positions within the 16-byte frame.
    localparam logic [3:0] POS_HDR_A  = 4'd0;
    localparam logic [3:0] POS_HDR_B  = 4'd8;
    localparam logic [3:0] POS_FOOT_A = 4'd3;
    localparam logic [3:0] POS_FOOT_B = 4'd11;
    localparam logic [3:0] POS_DGAP_A = 4'd7;
    localparam logic [3:0] POS_DGAP_B = 4'd15;

    // What follows the eight data bits of a byte.
    localparam logic [1:0] TRL_NONE   = 2'd0;
    localparam logic [1:0] TRL_FOOTER = 2'd1;
    localparam logic [1:0] TRL_DGAP   = 2'd2;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       hdr;
        logic [1:0] trailer;
        logic       frame_end;
    } desc_t;

endpackage

// ===== hdl/ipd_front.sv =====
module ipd_front
    import ipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       q_full,
    output logic       push,
    output desc_t      push_desc
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign pos_next = pos_reg + 4'd1;

    always_comb
    begin
        push_desc.byte_val  = byte_value;
        push_desc.hdr       = (pos_reg == POS_HDR_A) || (pos_reg == POS_HDR_B);
        push_desc.frame_end = (pos_reg == POS_DGAP_B);
        priority if ((pos_reg == POS_FOOT_A) || (pos_reg == POS_FOOT_B))
        begin
            push_desc.trailer = TRL_FOOTER;
        end
        else if ((pos_reg == POS_DGAP_A) || (pos_reg == POS_DGAP_B))
        begin
            push_desc.trailer = TRL_DGAP;
        end
        else
        begin
            push_desc.trailer = TRL_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== hdl/ipd_queue.sv =====
module ipd_queue
    import ipd_pkg::*;
#(
    parameter int unsigned DEPTH = IPD_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    desc_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

endmodule

// ===== hdl/ipd_back.sv =====
module ipd_back
    import ipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  tick,
    input  logic        head_valid,
    input  desc_t       head_desc,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] mark_us,
    output logic [16:0] space_us,
    output logic        last,
    output logic        frame_end
);

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic [3:0]  k;
    logic        advance;
    logic        pair_last;
    logic [6:0]  mark_t;
    logic [8:0]  space_t;
    logic [14:0] mark_prod;
    logic [16:0] space_prod;

    logic        out_valid_reg;
    logic [14:0] mark_reg;
    logic [16:0] space_reg;
    logic        last_reg;
    logic        frame_end_reg;

    // Step within the current byte; k counts from the first data bit.
    assign k = step_reg - {3'd0, head_desc.hdr};

    always_comb
    begin
        mark_t    = BIT_MARK_T;
        space_t   = ZERO_SPACE_T;
        pair_last = 1'b0;
        priority if (head_desc.hdr && (step_reg == 4'd0))
        begin
            mark_t  = HDR_MARK_T;
            space_t = HDR_SPACE_T;
        end
        else if (k < 4'd8)
        begin
            space_t   = head_desc.byte_val[k[2:0]] ? ONE_SPACE_T : ZERO_SPACE_T;
            pair_last = (k == 4'd7) && (head_desc.trailer == TRL_NONE);
        end
        else if (head_desc.trailer == TRL_DGAP)
        begin
            space_t   = DGAP_SPACE_T;
            pair_last = 1'b1;
        end
        else
        begin
            // Footer bits 0,1,0 and then the gap.
            priority if (k == 4'd9)
            begin
                space_t = ONE_SPACE_T;
            end
            else if (k >= 4'd11)
            begin
                space_t   = GAP_SPACE_T;
                pair_last = 1'b1;
            end
            else
            begin
                space_t = ZERO_SPACE_T;
            end
        end
    end

    assign mark_prod  = {8'd0, mark_t} * {7'd0, tick};
    assign space_prod = {8'd0, space_t} * {9'd0, tick};

    assign advance   = head_valid && (!out_valid_reg || out_ready);
    assign pop       = advance && pair_last;
    assign step_next = pair_last ? 4'd0 : step_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg <= step_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mark_reg      <= mark_prod;
            space_reg     <= space_prod;
            last_reg      <= pair_last;
            frame_end_reg <= pair_last && head_desc.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign mark_us   = mark_reg;
    assign space_us  = space_reg;
    assign last      = last_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== hdl/ir_pulse_distance_frame_encoder.sv =====
// The byte's descriptor is registered in the queue; its first pulse pair then passes to the output register.
// The single back-end sequencer emits one pulse pair per cycle while the output is not stalled;
// a byte causes 8 to 12 pairs.
// Bytes are taken every cycle until the descriptor queue (QUEUE_DEPTH entries) fills.
// Reset (rst_n low, asynchronous) clears the frame position, the queue and the output valid
// flag, and loads the tick register with 85 us.
module ir_pulse_distance_frame_encoder
    import ipd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = IPD_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  tick_us,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] mark_us,
    output logic [16:0] space_us,
    output logic        last,
    output logic        frame_end
);

    logic [7:0] tick_us_reg;
    logic       q_full;
    logic       push;
    desc_t      push_desc;
    logic       pop;
    logic       head_valid;
    desc_t      head_desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_us_reg <= TICK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tick_us_reg <= tick_us;
        end
    end

    ipd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .q_full     (q_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    ipd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    ipd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_us_reg),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mark_us    (mark_us),
        .space_us   (space_us),
        .last       (last),
        .frame_end  (frame_end)
    );

endmodule

// ===== hdl/ipd_checker.sv =====
module ipd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [7:0]  tick_us,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  byte_value,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] mark_us,
    input logic [16:0] space_us,
    input logic        last,
    input logic        frame_end
);

    // Bytes taken whose final pulse pair has not yet been delivered.
    logic [7:0] pending_reg;
    logic       in_xact;
    logic       out_done;

    assign in_xact  = in_valid && in_ready;
    assign out_done = out_valid && out_ready && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xact && !out_done)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (out_done && !in_xact)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mark_us) && $stable(space_us)
            && $stable(last) && $stable(frame_end))
        else $error("pulse pair changed while stalled");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> last)
        else $error("frame end flagged on a pair that does not close its byte");

    a_zero_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mark_us == 15'd0) |-> (space_us == 17'd0))
        else $error("zero mark with nonzero space");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 8'd0))
        else $error("pulse pair shown with no byte outstanding");

endmodule

bind ir_pulse_distance_frame_encoder ipd_checker u_ipd_checker (.*);

// ===== verif/ir_pulse_distance_frame_encoder_checker.sv =====
`timescale 1ns / 1ps
module ir_pulse_distance_frame_encoder_checker
    import ipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  tick_us,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [14:0] mark_us,
    input  logic [16:0] space_us,
    input  logic        last,
    input  logic        frame_end,
    output int unsigned error_count,
    output int unsigned pairs_outstanding
);

    typedef struct packed {
        logic [14:0] mark_us;
        logic [16:0] space_us;
        logic        last;
        logic        frame_end;
    } pulse_pair_t;

    pulse_pair_t expected_pairs[$];
    logic [7:0]  tick_len = TICK_RESET;
    logic [3:0]  frame_pos = '0;
    int unsigned mismatches = 0;
    int unsigned queued = 0;

    assign error_count       = mismatches;
    assign pairs_outstanding = queued;

    function automatic pulse_pair_t scale_pair(input logic [8:0] mark_t,
                                               input logic [8:0] space_t);
        logic [31:0] m;
        logic [31:0] s;
        pulse_pair_t p;
        m = 32'(mark_t) * 32'(tick_len);
        s = 32'(space_t) * 32'(tick_len);
        p.mark_us   = m[14:0];
        p.space_us  = s[16:0];
        p.last      = 1'b0;
        p.frame_end = 1'b0;
        return p;
    endfunction

    // Expands one frame byte into its pulse pairs and advances the frame position.
    function automatic void encode_byte(input logic [7:0] b);
        pulse_pair_t pairs[12];
        int n;
        int i;
        n = 0;
        if (frame_pos == POS_HDR_A || frame_pos == POS_HDR_B)
        begin
            pairs[n] = scale_pair(9'(HDR_MARK_T), HDR_SPACE_T);
            n++;
        end
        for (i = 0; i < 8; i++)
        begin
            pairs[n] = scale_pair(9'(BIT_MARK_T), b[i] ? ONE_SPACE_T : ZERO_SPACE_T);
            n++;
        end
        if (frame_pos == POS_FOOT_A || frame_pos == POS_FOOT_B)
        begin
            pairs[n]     = scale_pair(9'(BIT_MARK_T), ZERO_SPACE_T);
            pairs[n + 1] = scale_pair(9'(BIT_MARK_T), ONE_SPACE_T);
            pairs[n + 2] = scale_pair(9'(BIT_MARK_T), ZERO_SPACE_T);
            pairs[n + 3] = scale_pair(9'(BIT_MARK_T), GAP_SPACE_T);
            n += 4;
        end
        else if (frame_pos == POS_DGAP_A || frame_pos == POS_DGAP_B)
        begin
            pairs[n] = scale_pair(9'(BIT_MARK_T), DGAP_SPACE_T);
            n++;
        end
        pairs[n - 1].last      = 1'b1;
        pairs[n - 1].frame_end = (frame_pos == POS_DGAP_B);
        for (i = 0; i < n; i++)
        begin
            expected_pairs.push_back(pairs[i]);
        end
        frame_pos = frame_pos + 4'd1;
    endfunction

    function automatic void check_pair();
        pulse_pair_t got;
        pulse_pair_t want;
        got = '{mark_us, space_us, last, frame_end};
        if (expected_pairs.size() == 0)
        begin
            $display("%0t: unexpected pulse pair mark/space/last/frame_end %0d/%0d/%0b/%0b",
                     $time, got.mark_us, got.space_us, got.last, got.frame_end);
            mismatches++;
        end
        else
        begin
            want = expected_pairs.pop_front();
            if (got !== want)
            begin
                $display("%0t: mark/space/last/frame_end expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                         $time, want.mark_us, want.space_us, want.last, want.frame_end,
                         got.mark_us, got.space_us, got.last, got.frame_end);
                mismatches++;
            end
        end
    endfunction

    // Channels are sampled at the falling edge, where every signal is settled for the
    // rising edge that completes the transaction.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len  = TICK_RESET;
            frame_pos = '0;
            expected_pairs.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tick_len = tick_us;
            end
            if (in_valid && in_ready)
            begin
                encode_byte(byte_value);
            end
            if (out_valid && out_ready)
            begin
                check_pair();
            end
        end
        queued = expected_pairs.size();
    end

endmodule

// ===== verif/ir_pulse_distance_frame_encoder_test.sv =====
`timescale 1ns / 1ps
module ir_pulse_distance_frame_encoder_test;
    import ipd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  tick_us = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [14:0] mark_us;
    logic [16:0] space_us;
    logic        last;
    logic        frame_end;
    logic        no_idle = 1'b0;
    int unsigned error_count;
    int unsigned pairs_outstanding;

    logic [7:0] frame_bytes [16] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0,
                                     8'h00, 8'hFF, 8'h01, 8'h80, 8'hC3, 8'h3C, 8'h7E, 8'h81};

    ir_pulse_distance_frame_encoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .tick_us    (tick_us),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mark_us    (mark_us),
        .space_us   (space_us),
        .last       (last),
        .frame_end  (frame_end)
    );

    ir_pulse_distance_frame_encoder_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .tick_us           (tick_us),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .byte_value        (byte_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .mark_us           (mark_us),
        .space_us          (space_us),
        .last              (last),
        .frame_end         (frame_end),
        .error_count       (error_count),
        .pairs_outstanding (pairs_outstanding)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 6);
    end

    // Ready is read at the falling edge, where it already holds its value for the next
    // rising edge.
    task automatic send_byte(input logic [7:0] b);
        logic taken;
        while (!no_idle && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic write_tick(input logic [7:0] t);
        logic taken;
        cfg_valid <= 1'b1;
        tick_us   <= t;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Holds the sender off until every predicted pulse pair has been seen.
    task automatic drain_pairs();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pairs_outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One full frame at the reset tick, then a restart of the frame at the extremes.
        for (k = 0; k < 16; k++)
        begin
            send_byte(frame_bytes[k]);
        end
        drain_pairs();
        write_tick(8'd255);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        drain_pairs();
        // A zero tick keeps the pair sequence but zeroes every duration.
        write_tick(8'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain_pairs();
        write_tick(8'd1);
        send_byte(8'hFF);
        drain_pairs();

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                1:       write_tick(8'd255);
                2:       write_tick(8'd1);
                4:       write_tick(8'd0);
                6:       write_tick(TICK_RESET);
                default: write_tick(8'($urandom_range(1, 255)));
            endcase
            no_idle <= (phase == 0);
            for (k = 0; k < 50; k++)
            begin
                if (phase == 3 && k == 20)
                begin
                    drain_pairs();
                end
                send_byte(8'($urandom_range(0, 255)));
            end
            drain_pairs();
        end

        no_idle <= 1'b0;
        repeat (20) @(posedge clk);
        if (error_count == 0 && pairs_outstanding == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
